// File: rtl/core/wsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsa_pkg
// Shared types and constants for the watch slot free list allocator.
// ----------------------------------------------------------------------------
package wsa_pkg;

  localparam int POOL_SIZE  = 32;
  localparam int IDX_W      = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CNT_W      = $clog2(POOL_SIZE + 1);
  localparam int SLOT_NUM_W = 5;
  localparam int STATUS_W   = 2;
  localparam int CMP_W      = 10;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_NOT_IN_USE = 2'd2
  } status_e;

  typedef struct packed {
    logic             pop;
    logic             push;
    logic [IDX_W-1:0] push_slot;
  } stack_cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/wsa_stack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsa_stack
// Free slot stack in a synchronous memory with a stack pointer. A low-water
// mark stands in for the reset contents: entries below it read as their
// reset value.
// ----------------------------------------------------------------------------
module wsa_stack (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                rd_en_i,
  input  wire wsa_pkg::stack_cmd_t cmd_i,
  output logic [wsa_pkg::IDX_W-1:0] top_slot_o,
  output logic                     empty_o,
  output logic [wsa_pkg::CNT_W-1:0] count_o
);
  import wsa_pkg::*;

  logic [IDX_W-1:0] mem [POOL_SIZE];
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] low_mark_q, low_mark_d;
  logic [IDX_W-1:0] rd_data_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             rd_fresh_q;
  logic [IDX_W-1:0] rd_idx;
  logic [CNT_W-1:0] cnt_dec;
  logic             full;

  assign cnt_dec = count_q - CNT_W'(1);
  assign rd_idx  = cnt_dec[IDX_W-1:0];
  assign full    = (count_q == CNT_W'(POOL_SIZE));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

  // top of stack, reset contents below the low-water mark
  assign top_slot_o = rd_fresh_q ? (IDX_W'(POOL_SIZE - 1) - rd_idx_q) : rd_data_q;

  always_comb begin
    count_d    = count_q;
    low_mark_d = low_mark_q;
    if (cmd_i.pop && !empty_o) begin
      count_d = cnt_dec;
      if (cnt_dec < low_mark_q) begin
        low_mark_d = cnt_dec;
      end
    end else if (cmd_i.push && !full) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= CNT_W'(POOL_SIZE);
      low_mark_q <= CNT_W'(POOL_SIZE);
    end else begin
      count_q    <= count_d;
      low_mark_q <= low_mark_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q  <= mem[rd_idx];
      rd_idx_q   <= rd_idx;
      rd_fresh_q <= (CNT_W'(rd_idx) < low_mark_q);
    end
    if (cmd_i.push && !cmd_i.pop && !full) begin
      mem[count_q[IDX_W-1:0]] <= cmd_i.push_slot;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/watch_slot_free_list_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// watch_slot_free_list_allocator
// LIFO free list slot allocator: allocate pops the most recently freed slot,
// release checks the in-use bitmap and pushes the slot back.
// ----------------------------------------------------------------------------
// sequence: the accepting edge latches the word and reads the stack memory,
//   then S_EXEC does the read-modify-write of stack and bitmap and registers
//   the result strobe and result word
// a new word is held off (busy) while one is in S_EXEC
// reset: stack full in reset order, bitmap clear, no clearing pass needed
// results are shown for one cycle; the receiver cannot stall
// ----------------------------------------------------------------------------
module watch_slot_free_list_allocator (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        op_i,
  input  wire logic [wsa_pkg::SLOT_NUM_W-1:0] slot_number_i,
  output logic                             done_o,
  output logic [wsa_pkg::STATUS_W-1:0]     status_o,
  output logic [wsa_pkg::SLOT_NUM_W-1:0]   granted_slot_o
);
  import wsa_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e                state_q;
  op_e                   op_q;
  logic [SLOT_NUM_W-1:0] slot_q;
  logic [POOL_SIZE-1:0]  in_use_q, in_use_d;
  logic                  done_q;
  status_e               status_q, status_d;
  logic [SLOT_NUM_W-1:0] granted_q, granted_d;

  stack_cmd_t            cmd;
  logic [IDX_W-1:0]      top_slot;
  logic                  stack_empty;
  logic [CNT_W-1:0]      stack_count;
  logic                  accept;
  logic [IDX_W-1:0]      slot_idx;
  logic                  slot_in_range;

  assign accept        = start && !busy;
  assign busy          = (state_q == S_EXEC);
  assign slot_idx      = IDX_W'({{IDX_W{1'b0}}, slot_q});
  assign slot_in_range = ({{(CMP_W - SLOT_NUM_W){1'b0}}, slot_q} < CMP_W'(POOL_SIZE));

  wsa_stack u_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .cmd_i      (cmd),
    .top_slot_o (top_slot),
    .empty_o    (stack_empty),
    .count_o    (stack_count)
  );

  always_comb begin
    cmd       = '0;
    in_use_d  = in_use_q;
    status_d  = ST_OK;
    granted_d = '0;
    if (state_q == S_EXEC) begin
      unique case (op_q)
        OP_ALLOC: begin
          if (stack_empty) begin
            status_d = ST_EMPTY;
          end else begin
            cmd.pop            = 1'b1;
            in_use_d[top_slot] = 1'b1;
            granted_d          = SLOT_NUM_W'({{SLOT_NUM_W{1'b0}}, top_slot});
          end
        end
        OP_RELEASE: begin
          if (!slot_in_range || !in_use_q[slot_idx]) begin
            status_d = ST_NOT_IN_USE;
          end else begin
            in_use_d[slot_idx] = 1'b0;
            cmd.push           = 1'b1;
            cmd.push_slot      = slot_idx;
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= OP_ALLOC;
      slot_q    <= '0;
      in_use_q  <= '0;
      done_q    <= 1'b0;
      status_q  <= ST_OK;
      granted_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            op_q    <= op_e'(op_i);
            slot_q  <= slot_number_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          in_use_q  <= in_use_d;
          status_q  <= status_d;
          granted_q <= granted_d;
          done_q    <= 1'b1;
          state_q   <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign granted_slot_o = granted_q;

  // one word in flight at a time
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && !done_o) else $error("accepted word did not enter execution");

  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> done_o && !busy) else $error("execution did not produce a result");

  a_err_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ST_OK) |-> (granted_slot_o == '0))
    else $error("granted slot nonzero on error status");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stack_count <= CNT_W'(POOL_SIZE)) else $error("free count beyond pool size");

  a_bitmap_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && !done_o |-> ($countones(in_use_q) + stack_count == POOL_SIZE))
    else $error("bitmap and free stack disagree");

endmodule
`default_nettype wire

// File: tb/tb_watch_slot_free_list_allocator.sv
// ----------------------------------------------------------------------------
// tb_watch_slot_free_list_allocator
// Self-checking bench for the LIFO slot allocator. A short table of directed
// requests walks the pool from reset to empty and back, then random request
// streams fill and drain the pool with stray releases mixed in. A local model
// of the free stack and in-use bitmap predicts untyped results; typed rows set their own.
// ----------------------------------------------------------------------------
module tb_watch_slot_free_list_allocator;
  import wsa_pkg::*;

  typedef struct {
    status_e                st;
    logic [SLOT_NUM_W-1:0]  gs;
  } slot_result_t;

  typedef struct {
    op_e                    op;
    logic [SLOT_NUM_W-1:0]  slot;
    int                     reps;
    bit                     typed;
    status_e                st;
    logic [SLOT_NUM_W-1:0]  gs;
  } dir_row_t;

  localparam int NUM_ITEMS  = 650;
  localparam int QUIET_TAIL = 100;
  localparam int WDOG_LIMIT = 2000;
  localparam int NUM_ROWS   = 17;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  op_i = 1'b0;
  logic [SLOT_NUM_W-1:0] slot_number_i = '0;
  logic                  done_o;
  logic [STATUS_W-1:0]   status_o;
  logic [SLOT_NUM_W-1:0] granted_slot_o;

  bit                    row_typed = 1'b0;
  status_e               row_st = ST_OK;
  logic [SLOT_NUM_W-1:0] row_gs = '0;

  logic [SLOT_NUM_W-1:0] free_stk [POOL_SIZE];
  int                    free_cnt;
  bit                    slot_busy [POOL_SIZE];
  slot_result_t          pending_results [$];

  int errors = 0;
  int idle_cycles = 0;
  int n_alloc_ok = 0;
  int n_empty = 0;
  int n_rel_ok = 0;
  int n_not_in_use = 0;

  dir_row_t dir_rows [NUM_ROWS] = '{
    '{OP_ALLOC,   5'd31, 1,  1'b1, ST_OK,         5'd0},
    '{OP_ALLOC,   5'd0,  1,  1'b1, ST_OK,         5'd1},
    '{OP_RELEASE, 5'd31, 1,  1'b1, ST_NOT_IN_USE, 5'd0},
    '{OP_RELEASE, 5'd1,  1,  1'b1, ST_OK,         5'd0},
    '{OP_RELEASE, 5'd1,  1,  1'b1, ST_NOT_IN_USE, 5'd0},
    '{OP_ALLOC,   5'h15, 1,  1'b1, ST_OK,         5'd1},
    '{OP_RELEASE, 5'd0,  1,  1'b0, ST_OK,         5'd0},
    '{OP_RELEASE, 5'd1,  1,  1'b0, ST_OK,         5'd0},
    '{OP_ALLOC,   5'h0a, 2,  1'b0, ST_OK,         5'd0},
    '{OP_ALLOC,   5'h0a, 30, 1'b0, ST_OK,         5'd0},
    '{OP_ALLOC,   5'h1f, 1,  1'b1, ST_EMPTY,      5'd0},
    '{OP_ALLOC,   5'd0,  1,  1'b1, ST_EMPTY,      5'd0},
    '{OP_RELEASE, 5'd31, 1,  1'b1, ST_OK,         5'd0},
    '{OP_RELEASE, 5'd16, 1,  1'b1, ST_OK,         5'd0},
    '{OP_ALLOC,   5'd0,  1,  1'b1, ST_OK,         5'd16},
    '{OP_ALLOC,   5'd0,  1,  1'b1, ST_OK,         5'd31},
    '{OP_ALLOC,   5'd0,  1,  1'b1, ST_EMPTY,      5'd0}
  };

  watch_slot_free_list_allocator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .slot_number_i  (slot_number_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .granted_slot_o (granted_slot_o)
  );

  always #2 clk_i = ~clk_i;

  // free stack and bitmap, updated once per accepted word
  task automatic alloc_model_step(input op_e op, input logic [SLOT_NUM_W-1:0] slot,
                                  output slot_result_t res);
    int s;
    res.st = ST_OK;
    res.gs = '0;
    if (op == OP_ALLOC) begin
      if (free_cnt == 0 || free_cnt > POOL_SIZE) begin
        res.st = ST_EMPTY;
      end else begin
        free_cnt--;
        s = int'(free_stk[free_cnt]);
        if (s < POOL_SIZE) slot_busy[s] = 1'b1;
        res.gs = s[SLOT_NUM_W-1:0];
      end
    end else begin
      if (int'(slot) >= POOL_SIZE || !slot_busy[slot]) begin
        res.st = ST_NOT_IN_USE;
      end else begin
        slot_busy[slot] = 1'b0;
        if (free_cnt < POOL_SIZE) begin
          free_stk[free_cnt] = slot;
          free_cnt++;
        end
      end
    end
  endtask

  // acceptance, prediction and checking in one process
  always @(posedge clk_i) begin
    slot_result_t res;
    slot_result_t exp_res;
    if (rst_ni) begin
      if (start && !busy) begin
        alloc_model_step(op_e'(op_i), slot_number_i, res);
        case (res.st)
          ST_OK:    if (op_i == OP_ALLOC) n_alloc_ok++; else n_rel_ok++;
          ST_EMPTY: n_empty++;
          default:  n_not_in_use++;
        endcase
        if (row_typed) begin
          res.st = row_st;
          res.gs = row_gs;
        end
        pending_results.push_back(res);
      end
      if (done_o) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected word status=%0d granted_slot=%0d",
                   $time, status_o, granted_slot_o);
          errors++;
        end else begin
          exp_res = pending_results.pop_front();
          if (status_o !== exp_res.st) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_res.st, status_o);
            errors++;
          end
          if (granted_slot_o !== exp_res.gs) begin
            $display("%0t: granted_slot expected %0d actual %0d",
                     $time, exp_res.gs, granted_slot_o);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, WDOG_LIMIT);
        $display("tb_watch_slot_free_list_allocator: errors");
        $finish;
      end
    end
  end

  task automatic send_word(input op_e op, input logic [SLOT_NUM_W-1:0] slot,
                           input bit typed, input status_e st,
                           input logic [SLOT_NUM_W-1:0] gs, input bit may_gap);
    int gap;
    if (may_gap && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start = 1'b1;
    op_i = op;
    slot_number_i = slot;
    row_typed = typed;
    row_st = st;
    row_gs = gs;
    do @(posedge clk_i); while (!(start && !busy));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    int mode;
    int pick;
    int busy_list [$];
    op_e op;
    logic [SLOT_NUM_W-1:0] slot;
    for (int i = 0; i < POOL_SIZE; i++) begin
      free_stk[i] = SLOT_NUM_W'(POOL_SIZE - 1 - i);
      slot_busy[i] = 1'b0;
    end
    free_cnt = POOL_SIZE;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].reps; k++) begin
        send_word(dir_rows[r].op, dir_rows[r].slot, dir_rows[r].typed,
                  dir_rows[r].st, dir_rows[r].gs, 1'b1);
      end
    end
    drain_results();

    mode = 0;
    for (int n = 0; n < NUM_ITEMS; n++) begin
      if (n % 80 == 0) mode = $urandom_range(0, 2);
      if (n == NUM_ITEMS / 2) drain_results();
      busy_list.delete();
      for (int s = 0; s < POOL_SIZE; s++) if (slot_busy[s]) busy_list.push_back(s);
      pick = $urandom_range(0, 99);
      slot = SLOT_NUM_W'($urandom);
      if (pick < 15) begin
        op = op_e'($urandom_range(0, 1));
      end else begin
        case (mode)
          0:       op = (pick < 75) ? OP_ALLOC : OP_RELEASE;
          1:       op = (pick < 75) ? OP_RELEASE : OP_ALLOC;
          default: op = (pick < 57) ? OP_ALLOC : OP_RELEASE;
        endcase
        if (op == OP_RELEASE) begin
          if (busy_list.size() == 0) op = OP_ALLOC;
          else slot = SLOT_NUM_W'(busy_list[$urandom_range(0, busy_list.size() - 1)]);
        end
      end
      send_word(op, slot, 1'b0, ST_OK, '0, n < NUM_ITEMS - QUIET_TAIL);
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    $display("covered %0d good allocs, %0d empty pool, %0d good releases, %0d bad releases",
             n_alloc_ok, n_empty, n_rel_ok, n_not_in_use);
    if (errors == 0) begin
      $display("tb_watch_slot_free_list_allocator: clean");
    end else begin
      $display("tb_watch_slot_free_list_allocator: errors");
    end
    $finish;
  end

endmodule
